// ===== rtl/core/lbs_pkg.sv =====
// constants and types shared by the linear blend skinning block
`default_nettype none

package lbs_pkg;

    // palette geometry
    localparam int BONES     = 64;
    localparam int WORDS     = 12;
    localparam int N_INF     = 4;
    localparam int BONE_W    = (BONES > 1) ? $clog2(BONES) : 1;
    localparam int PAL_WORDS = BONES * WORDS;

    // item field widths
    localparam int ADDR_W = 10;
    localparam int ID_W   = 6;
    localparam int W_W    = 17;

    // datapath widths
    localparam int PROD_W = 64;
    localparam int SUM3_W = 66;
    localparam int T_W    = 51;
    localparam int C_W    = 53;
    localparam int ACC_W  = 55;

    // item kinds
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_SKIN  = 1'b1
    } t_kind;

    typedef logic signed [31:0] t_word;

endpackage

`default_nettype wire

// ===== rtl/core/linear_blend_vertex_skinning.sv =====
// linear blend skinning pipeline with a replicated bone palette
//
// Skins one vertex per clock while the output is not stalled, four influences per vertex.
// A palette write item yields no result; a vertex item passes through a six stage
// pipeline: palette read, 36 coordinate multiplies, row sums, 12 weight multiplies,
// influence sums, saturation. The palette is held in 48 banks (one per influence and
// matrix word) so all 48 words a vertex needs are read in its accept cycle; a write
// item updates the same word in all four influence copies. Stalls on the output back
// up stage by stage, so empty stages still take new items.
`default_nettype none

module linear_blend_vertex_skinning
    import lbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [W_W-1:0]        i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_kind,
    input  wire logic [ADDR_W-1:0]     i_entry_addr,
    input  wire logic signed [31:0]    i_entry_value,
    input  wire logic signed [31:0]    i_pos_x,
    input  wire logic signed [31:0]    i_pos_y,
    input  wire logic signed [31:0]    i_pos_z,
    input  wire logic [4*ID_W-1:0]     i_bone_ids,
    input  wire logic [W_W-1:0]        i_weight_0,
    input  wire logic [W_W-1:0]        i_weight_1,
    input  wire logic [W_W-1:0]        i_weight_2,
    input  wire logic [W_W-1:0]        i_weight_3,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [31:0]         o_skin_x,
    output logic signed [31:0]         o_skin_y,
    output logic signed [31:0]         o_skin_z,
    output logic                       o_clipped
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);
    localparam logic [11:0] PAL_LIMIT = 12'(PAL_WORDS);
    localparam logic [8:0]  BONE_LIMIT = 9'(BONES);

    // configuration
    logic [W_W-1:0] r_floor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= W_W'(6);
        end else if (i_cfg_valid) begin
            r_floor <= i_cfg_data;
        end
    end

    // stage valid bits and backpressure chain
    logic [6:1] r_v;
    logic [7:1] rdy;
    logic       in_acc;

    always_comb begin
        rdy[7] = !i_out_stall;
        for (int k = 6; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_in_stall = !rdy[1];
    assign in_acc     = i_in_valid && rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) r_v[1] <= in_acc && (t_kind'(i_kind) == KIND_SKIN);
            for (int k = 2; k <= 6; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // write address split: bone = addr / 12, word = addr % 12
    logic [7:0] wr_quad;
    logic [7:0] wr_bone;
    logic [1:0] wr_row;
    logic [3:0] wr_word;
    logic       wr_en;
    logic [16:0] quad_mul;

    always_comb begin
        wr_quad  = i_entry_addr[ADDR_W-1:2];
        quad_mul = 17'(wr_quad) * 17'd171;
        wr_bone  = {1'b0, quad_mul[15:9]};
        wr_row   = 2'(wr_quad - 8'(wr_bone * 8'd3));
        wr_word  = {wr_row, i_entry_addr[1:0]};
        wr_en    = in_acc && (t_kind'(i_kind) == KIND_WRITE)
                   && ({2'b0, i_entry_addr} < PAL_LIMIT);
    end

    // influence decode: bone index and enabled weight
    logic [7:0]     id  [N_INF];
    logic [W_W-1:0] wt  [N_INF];
    logic [W_W-1:0] w_eff [N_INF];

    always_comb begin
        wt[0] = i_weight_0;
        wt[1] = i_weight_1;
        wt[2] = i_weight_2;
        wt[3] = i_weight_3;
        for (int i = 0; i < N_INF; i++) begin
            id[i]    = {2'b0, i_bone_ids[i*ID_W +: ID_W]};
            w_eff[i] = ((wt[i] > r_floor) && ({1'b0, id[i]} < BONE_LIMIT)) ? wt[i] : '0;
        end
    end

    // palette banks, one per influence and word
    logic [31:0] r_mem [N_INF][WORDS][BONES];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_INF; i++) begin
            for (int k = 0; k < WORDS; k++) begin
                if (wr_en && (wr_word == 4'(k))) begin
                    r_mem[i][k][wr_bone[BONE_W-1:0]] <= i_entry_value;
                end
            end
        end
    end

    // stage 1: palette read and operand capture
    t_word          r1_m   [N_INF][WORDS];
    t_word          r1_pos [3];
    logic [W_W-1:0] r1_w   [N_INF];

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_pos[0] <= i_pos_x;
            r1_pos[1] <= i_pos_y;
            r1_pos[2] <= i_pos_z;
            for (int i = 0; i < N_INF; i++) begin
                r1_w[i] <= w_eff[i];
                for (int k = 0; k < WORDS; k++) begin
                    r1_m[i][k] <= r_mem[i][k][id[i][BONE_W-1:0]];
                end
            end
        end
    end

    // stage 2: matrix element times coordinate
    logic signed [PROD_W-1:0] r2_p  [N_INF][3][3];
    t_word                    r2_tr [N_INF][3];
    logic [W_W-1:0]           r2_w  [N_INF];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            for (int i = 0; i < N_INF; i++) begin
                r2_w[i] <= r1_w[i];
                for (int r = 0; r < 3; r++) begin
                    r2_tr[i][r] <= r1_m[i][r*4+3];
                    for (int c = 0; c < 3; c++) begin
                        r2_p[i][r][c] <= PROD_W'(r1_m[i][r*4+c]) * PROD_W'(r1_pos[c]);
                    end
                end
            end
        end
    end

    // stage 3: row sum, drop fraction, add translation
    logic signed [SUM3_W-1:0] row_sum [N_INF][3];
    logic signed [T_W-1:0]    r3_t    [N_INF][3];
    logic [W_W-1:0]           r3_w    [N_INF];

    always_comb begin
        for (int i = 0; i < N_INF; i++) begin
            for (int r = 0; r < 3; r++) begin
                row_sum[i][r] = SUM3_W'(r2_p[i][r][0]) + SUM3_W'(r2_p[i][r][1])
                                + SUM3_W'(r2_p[i][r][2]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            for (int i = 0; i < N_INF; i++) begin
                r3_w[i] <= r2_w[i];
                for (int r = 0; r < 3; r++) begin
                    r3_t[i][r] <= T_W'($signed(row_sum[i][r][SUM3_W-1:16]))
                                  + T_W'(r2_tr[i][r]);
                end
            end
        end
    end

    // stage 4: scale by weight, floor of the fraction
    logic signed [T_W+W_W:0] wprod [N_INF][3];
    logic signed [C_W-1:0]   r4_c  [N_INF][3];

    always_comb begin
        for (int i = 0; i < N_INF; i++) begin
            for (int r = 0; r < 3; r++) begin
                wprod[i][r] = (T_W+W_W+1)'(r3_t[i][r])
                              * (T_W+W_W+1)'($signed({1'b0, r3_w[i]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            for (int i = 0; i < N_INF; i++) begin
                for (int r = 0; r < 3; r++) begin
                    r4_c[i][r] <= wprod[i][r][T_W+W_W:16];
                end
            end
        end
    end

    // stage 5: sum the four influences
    logic signed [ACC_W-1:0] r5_s [3];

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            for (int r = 0; r < 3; r++) begin
                r5_s[r] <= ACC_W'(r4_c[0][r]) + ACC_W'(r4_c[1][r])
                           + ACC_W'(r4_c[2][r]) + ACC_W'(r4_c[3][r]);
            end
        end
    end

    // stage 6: saturate into the output register
    t_word sat [3];
    logic  [2:0] hit;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            hit[r] = 1'b1;
            if (r5_s[r] > SAT_MAX) begin
                sat[r] = 32'sh7fffffff;
            end else if (r5_s[r] < SAT_MIN) begin
                sat[r] = 32'sh80000000;
            end else begin
                sat[r] = r5_s[r][31:0];
                hit[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            o_skin_x  <= sat[0];
            o_skin_y  <= sat[1];
            o_skin_z  <= sat[2];
            o_clipped <= |hit;
        end
    end

    assign o_out_valid = r_v[6];

`ifndef ASSERT_OFF
    // a stall at the input means the first stage holds a vertex
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v[1])
        else $error("input stalled with empty first stage");

    // palette writes never become results
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_kind) |=> !r_v[1])
        else $error("palette write entered the pipeline");

    // a clipped result sits at a rail
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            (o_skin_x == 32'sh7fffffff || o_skin_x == 32'sh80000000 ||
             o_skin_y == 32'sh7fffffff || o_skin_y == 32'sh80000000 ||
             o_skin_z == 32'sh7fffffff || o_skin_z == 32'sh80000000))
        else $error("clipped set without a saturated coordinate");
`endif

endmodule

`default_nettype wire
